>>> rtl/core/iaf_pkg.sv
// iaf_pkg: shared types, constants and helpers of the integer to ascii formatter
// used by iaf_ctrl, iaf_dp and the top level; no dependencies
`default_nettype none

package iaf_pkg;

  typedef enum logic [1:0] {
    ACT_UDEC = 2'd0,
    ACT_SDEC = 2'd1,
    ACT_HEXU = 2'd2,
    ACT_HEXL = 2'd3
  } action_t;

  localparam int VALUE_W = 32;
  localparam int DEC_DIGITS = 10;
  localparam int DIG_W = 4 * DEC_DIGITS;
  localparam int ITER_W = $clog2(VALUE_W);

  localparam logic [3:0] DEC_CNT = 4'd10;
  localparam logic [3:0] HEX_CNT = 4'd8;
  localparam logic [3:0] DIGIT_TEN = 4'd10;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_hex;
    logic neg;
    logic top_zero;
    logic rem_one;
    logic slot_free;
  } dp_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] res;
    begin
      if (d < DIGIT_TEN) begin
        res = CH_ZERO + {4'h0, d};
      end else if (lower) begin
        res = CH_LOWER_A + {4'h0, d - DIGIT_TEN};
      end else begin
        res = CH_UPPER_A + {4'h0, d - DIGIT_TEN};
      end
      return res;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/iaf_dp.sv
// iaf_dp: datapath of the formatter: shift-add bcd converter, digit register,
// leading zero skip and the output character register; depends on iaf_pkg
`default_nettype none

module iaf_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        in_action,
  input  wire logic [31:0]       in_value,
  input  wire iaf_pkg::dp_cmd_t  cmd,
  output iaf_pkg::dp_sts_t       sts,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);
  import iaf_pkg::*;

  logic [VALUE_W-1:0] bin_r;
  logic [DIG_W-1:0]   dig_r;
  logic [3:0]         rem_r;
  logic               hex_r;
  logic               lower_r;
  logic               neg_r;
  logic               out_valid_r;
  logic [7:0]         out_char_r;
  logic               out_last_r;

  action_t            act;
  logic               ld_hex;
  logic               ld_neg;
  logic [VALUE_W-1:0] ld_mag;
  logic [DIG_W-1:0]   adj;
  logic [DIG_W+VALUE_W-1:0] shifted;

  assign act    = action_t'(in_action);
  assign ld_hex = (act == ACT_HEXU) || (act == ACT_HEXL);
  assign ld_neg = (act == ACT_SDEC) && in_value[VALUE_W-1];
  assign ld_mag = ld_neg ? (~in_value + 32'd1) : in_value;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
    end
  end

  assign shifted = {adj[DIG_W-2:0], bin_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r   <= ld_mag;
      dig_r   <= ld_hex ? {ld_mag, 8'h00} : '0;
      rem_r   <= ld_hex ? HEX_CNT : DEC_CNT;
      hex_r   <= ld_hex;
      lower_r <= (act == ACT_HEXL);
      neg_r   <= ld_neg;
    end else if (cmd.dabble) begin
      dig_r <= shifted[DIG_W+VALUE_W-1:VALUE_W];
      bin_r <= shifted[VALUE_W-1:0];
    end else if (cmd.skip || cmd.emit_digit) begin
      dig_r <= {dig_r[DIG_W-5:0], 4'h0};
      rem_r <= rem_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CH_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= digit_char(dig_r[DIG_W-1 -: 4], lower_r);
      out_last_r <= (rem_r == 4'd1);
    end
  end

  assign sts.is_hex    = hex_r;
  assign sts.neg       = neg_r;
  assign sts.top_zero  = (dig_r[DIG_W-1 -: 4] == 4'h0);
  assign sts.rem_one   = (rem_r == 4'd1);
  assign sts.slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/core/iaf_ctrl.sv
// iaf_ctrl: state machine of the formatter that sequences conversion, zero skip
// and character emission through datapath commands; depends on iaf_pkg
`default_nettype none

module iaf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire iaf_pkg::dp_sts_t  sts,
  output iaf_pkg::dp_cmd_t       cmd
);
  import iaf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [ITER_W-1:0] iter_r;
  logic [ITER_W-1:0] iter_nxt;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.is_hex) begin
          state_nxt = ST_SKIP;
        end else begin
          cmd.dabble = 1'b1;
          iter_nxt   = iter_r + 1'b1;
          if (iter_r == ITER_W'(VALUE_W - 1)) begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, always keep the last one
        if (sts.top_zero && !sts.rem_one) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.rem_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/integer_to_ascii_formatter_top.sv
// integer_to_ascii_formatter_top: formats a 32-bit word as ascii decimal or hex
// text; instantiates iaf_ctrl and iaf_dp, uses iaf_pkg
//
// input channel: in_tuser carries the format (0 unsigned decimal, 1 signed
// decimal, 2 upper-case hex, 3 lower-case hex), in_tdata the word.
// output channel: one item per character, most significant digit first, no
// leading zeros, a leading '-' for negative signed values; tlast marks the
// final character of each number.
// timing: one word at a time. decimal words pass through the shift-add bcd
// converter and hex words bypass it; then the leading zero skip drops leading
// zero digits one by one (up to 9 for a decimal word, 7 for a hex word), and
// each character then passes through the output register.
// in_tready rises once the last character sits in the output register, so the
// next word is taken while that character still waits to be read.
// a stalled receiver holds the output register and halts emission.
// reset returns the controller to idle and empties the output register.
`default_nettype none

module integer_to_ascii_formatter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_char
  output logic             out_tlast
);
  import iaf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iaf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/core/iaf_checker.sv
// iaf_checker: port-level assertions for integer_to_ascii_formatter_top and the
// bind that attaches them; depends only on the top level's ports
`default_nettype none

module iaf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // one word at a time: no accept in the cycle after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // only digits, hex letters and the minus sign appear
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                   (out_tdata >= 8'h41 && out_tdata <= 8'h46) ||
                   (out_tdata >= 8'h61 && out_tdata <= 8'h66) ||
                   (out_tdata == 8'h2D))
    else $error("illegal output character");

  // a minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == 8'h2D) |-> !out_tlast)
    else $error("minus sign flagged as last");

endmodule

bind integer_to_ascii_formatter_top iaf_checker u_iaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
